>>> src/pcfa_pkg.sv
// Shared types, codes, constants and helpers for the penalty contact force accumulator.
package pcfa_pkg;

  localparam int NODE_W  = 12;
  localparam int CFG_W   = 32;
  localparam int FORCE_W = 48;
  // Working width of a force while terms are folded in, before saturation.
  localparam int ACC_W   = 63;

  // Input op codes; the remaining code reads like OP_READ.
  localparam logic [1:0] OP_ACCUM = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [0:0] {
    REG_STIFFNESS = 1'b0,
    REG_DAMPING   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_ACCUM,
    KIND_CLEAR,
    KIND_READ,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [NODE_W-1:0]   node;
    logic signed [15:0]  dir_x;
    logic signed [15:0]  dir_y;
    logic signed [15:0]  dir_z;
    logic [30:0]         depth;
    logic signed [31:0]  vel_x;
    logic signed [31:0]  vel_y;
    logic signed [31:0]  vel_z;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } q_ctl_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] x;
    logic signed [FORCE_W-1:0] y;
    logic signed [FORCE_W-1:0] z;
  } force3_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_FETCH,
    B_MUL,
    B_FINAL,
    B_DONE
  } back_state_t;

  typedef enum logic [3:0] {
    ST_PX, ST_PY, ST_PZ,
    ST_VX, ST_VY, ST_VZ,
    ST_Q,
    ST_KX, ST_KY, ST_KZ,
    ST_CX_LO, ST_CX_HI,
    ST_CY_LO, ST_CY_HI,
    ST_CZ_LO, ST_CZ_HI
  } mul_step_t;

  localparam logic [60:0] MAG_CAP = 61'd1 << 60;
  localparam logic signed [FORCE_W-1:0] FORCE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = 48'sh8000_0000_0000;
  localparam logic signed [ACC_W-1:0]   ACC_FMAX  = 63'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0]   ACC_FMIN  = 63'sh7FFF_8000_0000_0000;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [FORCE_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [FORCE_W-1:0] r;
    priority if (v > ACC_FMAX) r = FORCE_MAX;
    else if (v < ACC_FMIN)     r = FORCE_MIN;
    else                       r = v[FORCE_W-1:0];
    return r;
  endfunction

  // Axis that a multiply step works on.
  function automatic logic [1:0] step_axis(input mul_step_t s);
    logic [1:0] a;
    unique case (s)
      ST_PX, ST_VX, ST_KX, ST_CX_LO, ST_CX_HI: a = 2'd0;
      ST_PY, ST_VY, ST_KY, ST_CY_LO, ST_CY_HI: a = 2'd1;
      ST_PZ, ST_VZ, ST_KZ, ST_CZ_LO, ST_CZ_HI: a = 2'd2;
      default:                                 a = 2'd0;
    endcase
    return a;
  endfunction

endpackage

>>> src/pcfa_if.sv
// Valid/ready channel interfaces: contact items, force results, register writes.
interface pcfa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [11:0]        node;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic [30:0]        depth;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source (output valid, op, node, dir_x, dir_y, dir_z, depth, vel_x, vel_y, vel_z,
                  input ready);
  modport sink (input valid, op, node, dir_x, dir_y, dir_z, depth, vel_x, vel_y, vel_z,
                output ready);
endinterface

interface pcfa_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        out_node;
  logic signed [47:0] force_x;
  logic signed [47:0] force_y;
  logic signed [47:0] force_z;

  modport source (output valid, out_node, force_x, force_y, force_z, input ready);
  modport sink (input valid, out_node, force_x, force_y, force_z, output ready);
endinterface

interface pcfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/pcfa_front.sv
// Front end: classify incoming words and hold them in a two-entry queue.
module pcfa_front
  import pcfa_pkg::*;
#(
  parameter int NODE_COUNT = 4096
) (
  input  logic    clk,
  input  logic    rst,
  pcfa_in_if.sink items,
  input  q_ctl_t  ctl,
  output logic    head_valid,
  output cmd_t    head
);

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  cmd_t             q [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             push;
  logic             in_range;
  cmd_t             entry;

  assign in_range    = int'(items.node) < NODE_COUNT;
  assign items.ready = (count != QCntW'(QDepth)) && !ctl.clearing;
  assign push        = items.valid && items.ready;
  assign head_valid  = count != '0;
  assign head        = q[rd_ptr];

  always_comb begin
    entry       = '0;
    entry.node  = items.node;
    entry.dir_x = items.dir_x;
    entry.dir_y = items.dir_y;
    entry.dir_z = items.dir_z;
    entry.depth = items.depth;
    entry.vel_x = items.vel_x;
    entry.vel_y = items.vel_y;
    entry.vel_z = items.vel_z;
    if (!in_range) begin
      entry.kind = KIND_NONE;
    end else begin
      unique case (items.op)
        OP_ACCUM: entry.kind = KIND_ACCUM;
        OP_CLEAR: entry.kind = KIND_CLEAR;
        OP_READ:  entry.kind = KIND_READ;
        default:  entry.kind = KIND_READ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPtrW'(1);
      if (ctl.pop) rd_ptr <= rd_ptr + QPtrW'(1);
      unique case ({push, ctl.pop})
        2'b10:   count <= count + QCntW'(1);
        2'b01:   count <= count - QCntW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= entry;
  end

endmodule

>>> src/pcfa_back.sv
// Back end: force store, clearing sweep, shared multiplier sequencer and result register.
module pcfa_back
  import pcfa_pkg::*;
#(
  parameter int NODE_COUNT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  cmd_t              head,
  output q_ctl_t            ctl,
  input  logic [CFG_W-1:0]  stiffness,
  input  logic [CFG_W-1:0]  damping,
  pcfa_out_if.source        results
);

  localparam int MemDepth = (NODE_COUNT < (1 << NODE_W)) ? NODE_COUNT : (1 << NODE_W);
  localparam int AddrW    = $clog2(MemDepth);

  back_state_t state, state_next;
  mul_step_t   step;
  logic        phase;
  logic [1:0]  ax;

  force3_t            mem [MemDepth];
  force3_t            rdata;
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  force3_t            mem_wdata;
  logic [AddrW-1:0]   clr_addr;

  cmd_t                    cur;
  logic signed [ACC_W-1:0] acc [3];
  logic [32:0]             p_mag [3];
  logic signed [49:0]      dot;
  logic [49:0]             q_mag;
  logic                    q_neg;
  logic [66:0]             prod;
  logic [66:0]             c_lo;
  logic [60:0]             c_mag;
  logic                    c_neg;
  logic                    c_pend;
  logic [1:0]              c_axis;
  logic                    c_apply;

  logic [15:0] dmag [3];
  logic [31:0] vmag [3];
  logic        dneg [3];
  logic        vneg [3];
  logic [49:0] dot_abs;
  logic [33:0] s_mag;
  logic [33:0] mul_a;
  logic [32:0] mul_b;
  logic [82:0] c_full;
  logic [66:0] c_sh;
  logic [60:0] c_cap;
  logic [48:0] k_val;
  logic [49:0] dot_term;
  logic        is_c_hi;
  logic        out_free;
  logic        res_load;
  force3_t     result;

  assign ax       = step_axis(step);
  assign out_free = !results.valid || results.ready;
  assign is_c_hi  = (step == ST_CX_HI) || (step == ST_CY_HI) || (step == ST_CZ_HI);
  assign c_apply  = c_pend && ((state == B_FINAL) || !phase);

  assign dmag[0] = abs16(cur.dir_x);
  assign dmag[1] = abs16(cur.dir_y);
  assign dmag[2] = abs16(cur.dir_z);
  assign vmag[0] = abs32(cur.vel_x);
  assign vmag[1] = abs32(cur.vel_y);
  assign vmag[2] = abs32(cur.vel_z);
  assign dneg[0] = cur.dir_x[15];
  assign dneg[1] = cur.dir_y[15];
  assign dneg[2] = cur.dir_z[15];
  assign vneg[0] = cur.vel_x[31];
  assign vneg[1] = cur.vel_y[31];
  assign vneg[2] = cur.vel_z[31];

  assign dot_abs  = dot[49] ? 50'(-dot) : 50'(dot);
  assign s_mag    = dot_abs[47:14];
  assign k_val    = prod[64:16];
  assign dot_term = {3'b0, prod[46:0]};
  assign c_full   = {16'b0, c_lo} + {prod[48:0], 34'b0};
  assign c_sh     = c_full[82:16];
  assign c_cap    = (c_sh > 67'(MAG_CAP)) ? MAG_CAP : c_sh[60:0];

  assign result.x = sat48(acc[0]);
  assign result.y = sat48(acc[1]);
  assign result.z = sat48(acc[2]);

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      ST_PX, ST_PY, ST_PZ: begin
        mul_a = 34'(dmag[ax]);
        mul_b = 33'(cur.depth);
      end
      ST_VX, ST_VY, ST_VZ: begin
        mul_a = 34'(vmag[ax]);
        mul_b = 33'(dmag[ax]);
      end
      ST_Q: begin
        mul_a = s_mag;
        mul_b = 33'(damping);
      end
      ST_KX, ST_KY, ST_KZ: begin
        mul_a = 34'(stiffness);
        mul_b = p_mag[ax];
      end
      ST_CX_LO, ST_CY_LO, ST_CZ_LO: begin
        mul_a = q_mag[33:0];
        mul_b = p_mag[ax];
      end
      ST_CX_HI, ST_CY_HI, ST_CZ_HI: begin
        mul_a = 34'(q_mag[49:34]);
        mul_b = p_mag[ax];
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_addr == AddrW'(MemDepth - 1)) state_next = B_IDLE;
      B_IDLE: begin
        if (head_valid) begin
          if ((head.kind == KIND_ACCUM) || (head.kind == KIND_READ)) state_next = B_FETCH;
          else state_next = B_DONE;
        end
      end
      B_FETCH: state_next = (cur.kind == KIND_ACCUM) ? B_MUL : B_DONE;
      B_MUL:   if (phase && (step == ST_CZ_HI)) state_next = B_FINAL;
      B_FINAL: state_next = B_DONE;
      B_DONE:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    mem_we    = 1'b0;
    mem_waddr = cur.node[AddrW-1:0];
    mem_wdata = result;
    res_load  = 1'b0;
    unique case (state)
      B_CLEAR: begin
        ctl.clearing = 1'b1;
        mem_we       = 1'b1;
        mem_waddr    = clr_addr;
        mem_wdata    = '0;
      end
      B_IDLE: ctl.pop = head_valid;
      B_DONE: begin
        if (out_free) begin
          res_load = 1'b1;
          mem_we   = (cur.kind == KIND_ACCUM) || (cur.kind == KIND_CLEAR);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[head.node[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_CLEAR;
      clr_addr      <= '0;
      phase         <= 1'b0;
      step          <= ST_PX;
      c_pend        <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) clr_addr <= clr_addr + AddrW'(1);
      if (state == B_FETCH) begin
        phase <= 1'b0;
        step  <= ST_PX;
      end else if (state == B_MUL) begin
        phase <= !phase;
        if (phase && (step != ST_CZ_HI)) step <= mul_step_t'(step + 4'd1);
      end
      if ((state == B_MUL) && phase && is_c_hi) c_pend <= 1'b1;
      else if (c_apply) c_pend <= 1'b0;
      if (res_load) results.valid <= 1'b1;
      else if (results.ready) results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == B_IDLE) && head_valid) begin
      cur    <= head;
      acc[0] <= '0;
      acc[1] <= '0;
      acc[2] <= '0;
    end
    if (state == B_FETCH) begin
      acc[0] <= ACC_W'(rdata.x);
      acc[1] <= ACC_W'(rdata.y);
      acc[2] <= ACC_W'(rdata.z);
      dot    <= '0;
    end
    if ((state == B_MUL) && !phase) prod <= 67'(mul_a) * 67'(mul_b);
    if ((state == B_MUL) && phase) begin
      unique case (step)
        ST_PX, ST_PY, ST_PZ: p_mag[ax] <= prod[46:14];
        ST_VX, ST_VY, ST_VZ: dot <= (vneg[ax] ^ dneg[ax]) ? dot - dot_term : dot + dot_term;
        ST_Q: begin
          q_mag <= prod[65:16];
          q_neg <= dot[49];
        end
        ST_KX, ST_KY, ST_KZ:
          acc[ax] <= dneg[ax] ? acc[ax] + ACC_W'(k_val) : acc[ax] - ACC_W'(k_val);
        ST_CX_LO, ST_CY_LO, ST_CZ_LO: c_lo <= prod;
        ST_CX_HI, ST_CY_HI, ST_CZ_HI: begin
          c_mag  <= c_cap;
          c_neg  <= q_neg ^ dneg[ax];
          c_axis <= ax;
        end
      endcase
    end
    // Fold the damping term in the cycle after it is formed.
    if (c_apply) begin
      acc[c_axis] <= c_neg ? acc[c_axis] + ACC_W'(c_mag) : acc[c_axis] - ACC_W'(c_mag);
    end
    if (res_load) begin
      results.out_node <= cur.node;
      results.force_x  <= result.x;
      results.force_y  <= result.y;
      results.force_z  <= result.z;
    end
  end

endmodule

>>> src/penalty_contact_force_accumulator_unit.sv
// Penalty contact force accumulator: top level with register file and assertions.
// Flow: a contact word passes the idle, fetch, multiply, final and done states; a
//   read skips multiply and final; a clear or out-of-range node goes straight to
//   done. One word is in the back end at a time: the shared 33x34 multiplier runs
//   sixteen issue/consume pairs for a contact word; a two-word queue keeps input open.
// Reset: synchronous; afterwards the force store is zeroed one node per cycle
//   (min(NODE_COUNT, 4096) nodes) while input is held off; registers writable.
module penalty_contact_force_accumulator_unit
  import pcfa_pkg::*;
#(
  parameter int NODE_COUNT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  pcfa_in_if.sink     items,
  pcfa_out_if.source  results,
  pcfa_cfg_if.sink    cfg
);

  logic [CFG_W-1:0] stiffness;
  logic [CFG_W-1:0] damping;
  q_ctl_t           ctl;
  logic             head_valid;
  cmd_t             head;

  // Register writes are stored directly; hold off the write channel only in reset.
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= 32'd65536;
      damping   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_STIFFNESS: stiffness <= cfg.data;
        REG_DAMPING:   damping   <= cfg.data;
      endcase
    end
  end

  // Front: classify each word (contact, clear, read, node out of range) and queue it.
  pcfa_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .ctl       (ctl),
    .head_valid(head_valid),
    .head      (head)
  );

  // Back: read-modify-write of a contact word's node force through the shared
  // multiplier; each word then gets a saturated result word, written back for contact and clear.
  pcfa_back #(
    .NODE_COUNT(NODE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .ctl       (ctl),
    .stiffness (stiffness),
    .damping   (damping),
    .results   (results)
  );

  // No word enters while the store is still being zeroed.
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |-> !ctl.clearing)
    else $error("input word taken during store clear");

  // The back end only pops a queue that holds a word.
  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> head_valid)
    else $error("pop from empty queue");

  // No result can be presented while the store is being zeroed.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.clearing |-> !results.valid)
    else $error("result valid during store clear");

  // The clearing sweep runs once per reset.
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    $fell(ctl.clearing) |=> !ctl.clearing)
    else $error("store clear restarted");

endmodule
